@@ hw/rtl/csl_pkg.sv @@
// Shared definitions for the cursor sequence list: request and status codes,
// the control word format and the microprogram that drives the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_INS0 = 4'd1;
  localparam step_t S_INS1 = 4'd2;
  localparam step_t S_INS2 = 4'd3;
  localparam step_t S_FULL = 4'd4;
  localparam step_t S_REM0 = 4'd5;
  localparam step_t S_REM1 = 4'd6;
  localparam step_t S_VAL  = 4'd7;
  localparam step_t S_ADV0 = 4'd8;
  localparam step_t S_ADV1 = 4'd9;
  localparam step_t S_RST  = 4'd10;
  localparam step_t S_CHK  = 4'd11;
  localparam step_t S_CLR  = 4'd12;
  localparam step_t S_OUT  = 4'd13;

  typedef enum logic [3:0] {
    U_NOP,
    U_WAIT,
    U_ALLOC,
    U_LINK_NEW,
    U_LINK_PREV,
    U_ST_FULL,
    U_UNLINK,
    U_LOAD_VAL,
    U_STEP,
    U_RESTART,
    U_CHK_END,
    U_CLEAR,
    U_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_AT_END,
    C_FULL,
    C_DISPATCH,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic at_end;
    logic full;
    logic out_free;
  } flags_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    case (step)
      S_IDLE:  w = '{U_WAIT,      C_DISPATCH, S_IDLE};
      S_INS0:  w = '{U_ALLOC,     C_FULL,     S_FULL};
      S_INS1:  w = '{U_LINK_NEW,  C_NEXT,     S_IDLE};
      S_INS2:  w = '{U_LINK_PREV, C_ALWAYS,   S_OUT};
      S_FULL:  w = '{U_ST_FULL,   C_ALWAYS,   S_OUT};
      S_REM0:  w = '{U_NOP,       C_AT_END,   S_CHK};
      S_REM1:  w = '{U_UNLINK,    C_ALWAYS,   S_VAL};
      S_VAL:   w = '{U_LOAD_VAL,  C_ALWAYS,   S_OUT};
      S_ADV0:  w = '{U_NOP,       C_AT_END,   S_CHK};
      S_ADV1:  w = '{U_STEP,      C_ALWAYS,   S_VAL};
      S_RST:   w = '{U_RESTART,   C_ALWAYS,   S_VAL};
      S_CHK:   w = '{U_CHK_END,   C_ALWAYS,   S_OUT};
      S_CLR:   w = '{U_CLEAR,     C_ALWAYS,   S_OUT};
      S_OUT:   w = '{U_EMIT,      C_OUT_FREE, S_IDLE};
      default: w = '{U_NOP,       C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input logic [OPCODE_W-1:0] opcode);
    step_t s;
    case (opcode)
      OP_INSERT:  s = S_INS0;
      OP_REMOVE:  s = S_REM0;
      OP_ADVANCE: s = S_ADV0;
      OP_RESTART: s = S_RST;
      OP_READ:    s = S_CHK;
      OP_CLEAR:   s = S_CLR;
      default:    s = S_OUT;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/csl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/csl_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on csl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csl_seq (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  logic                              in_valid,
  input  wire  logic [csl_pkg::OPCODE_W-1:0]      opcode,
  input  wire  csl_pkg::flags_t                   flags,
  output logic                                    ready,
  output csl_pkg::ctrl_t                          ctrl
);

  csl_pkg::step_t step;
  csl_pkg::step_t step_next;

  assign ctrl  = csl_pkg::ucode(step);
  assign ready = (ctrl.cond == csl_pkg::C_DISPATCH) && !rst;

  always_comb begin
    case (ctrl.cond)
      csl_pkg::C_NEXT:     step_next = step + 4'd1;
      csl_pkg::C_ALWAYS:   step_next = ctrl.target;
      csl_pkg::C_AT_END:   step_next = flags.at_end ? ctrl.target : step + 4'd1;
      csl_pkg::C_FULL:     step_next = flags.full ? ctrl.target : step + 4'd1;
      csl_pkg::C_DISPATCH: step_next = in_valid ? csl_pkg::dispatch(opcode) : step;
      csl_pkg::C_OUT_FREE: step_next = flags.out_free ? ctrl.target : step;
      default:             step_next = csl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= csl_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csl_datapath.sv @@
// List datapath: header and cursor registers, node allocator, the value, link
// and free stack memories, and the output register. Depends on csl_pkg, csl_ram.
`timescale 1ns / 1ps
`default_nettype none

module csl_datapath #(
  parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  csl_pkg::ctrl_t                 ctrl,
  input  wire  logic [csl_pkg::VALUE_W-1:0]    value,
  output csl_pkg::flags_t                      flags,
  output logic                                 out_valid,
  input  wire  logic                           out_ready,
  output logic [csl_pkg::VALUE_W-1:0]          out_value,
  output logic [csl_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_at_end,
  output logic                                 out_empty
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PTR_W = $clog2(CAPACITY + 2);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] NULL_CODE   = PTR_W'(CAPACITY);
  localparam logic [PTR_W-1:0] HEADER_CODE = PTR_W'(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_CAP     = CNT_W'(CAPACITY);

  logic [PTR_W-1:0]            header_link;
  logic [PTR_W-1:0]            cursor_prev;
  logic [PTR_W-1:0]            cur;
  logic [DATA_WIDTH-1:0]       cur_val;
  logic [CNT_W-1:0]            free_top;
  logic [CNT_W-1:0]            never_used;
  logic [IDX_W-1:0]            node;
  logic                        from_stack;
  logic [DATA_WIDTH-1:0]       val;
  logic [csl_pkg::STATUS_W-1:0] status;

  logic [63:0]                 val_wide;
  logic [63:0]                 cur_wide;
  logic                        at_end;
  logic                        prev_is_header;
  logic [IDX_W-1:0]            node_sel;
  logic [CNT_W-1:0]            top_dec;
  logic                        emit;

  logic                        nv_we;
  logic [IDX_W-1:0]            nv_waddr;
  logic [IDX_W-1:0]            nv_raddr;
  logic [DATA_WIDTH-1:0]       nv_rdata;
  logic                        nl_we;
  logic [IDX_W-1:0]            nl_waddr;
  logic [PTR_W-1:0]            nl_wdata;
  logic [PTR_W-1:0]            nl_rdata;
  logic                        fs_we;
  logic [IDX_W-1:0]            fs_rdata;

  assign val_wide       = 64'(value);
  assign at_end         = (cur >= NULL_CODE);
  assign prev_is_header = (cursor_prev == HEADER_CODE);
  assign node_sel       = from_stack ? fs_rdata : node;
  assign top_dec        = CNT_W'(free_top - 1'b1);
  assign cur_wide       = at_end ? 64'd0 : 64'(cur_val);
  assign emit           = (ctrl.uop == csl_pkg::U_EMIT) && (!out_valid || out_ready);

  assign flags.at_end   = at_end;
  assign flags.full     = (free_top == '0) && (never_used == CNT_CAP);
  assign flags.out_free = !out_valid || out_ready;

  always_comb begin
    nv_we    = 1'b0;
    nv_waddr = node_sel;
    nv_raddr = nl_rdata[IDX_W-1:0];
    nl_we    = 1'b0;
    nl_waddr = cursor_prev[IDX_W-1:0];
    nl_wdata = nl_rdata;
    fs_we    = 1'b0;
    case (ctrl.uop)
      csl_pkg::U_LINK_NEW: begin
        nv_we    = 1'b1;
        nl_we    = 1'b1;
        nl_waddr = node_sel;
        nl_wdata = cur;
      end
      csl_pkg::U_LINK_PREV: begin
        nl_we    = !prev_is_header;
        nl_wdata = PTR_W'(node);
      end
      csl_pkg::U_UNLINK: begin
        nl_we = !prev_is_header;
        fs_we = (free_top < CNT_CAP);
      end
      csl_pkg::U_RESTART: begin
        nv_raddr = header_link[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  csl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_node_value (
    .clk   (clk),
    .we    (nv_we),
    .waddr (nv_waddr),
    .wdata (val),
    .raddr (nv_raddr),
    .rdata (nv_rdata)
  );

  csl_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_node_link (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (cur[IDX_W-1:0]),
    .rdata (nl_rdata)
  );

  csl_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (free_top[IDX_W-1:0]),
    .wdata (cur[IDX_W-1:0]),
    .raddr (top_dec[IDX_W-1:0]),
    .rdata (fs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_link <= NULL_CODE;
      cursor_prev <= HEADER_CODE;
      cur         <= NULL_CODE;
      free_top    <= '0;
      never_used  <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (ctrl.uop)
        csl_pkg::U_ALLOC: begin
          if (free_top != '0) begin
            free_top <= top_dec;
          end else if (never_used < CNT_CAP) begin
            never_used <= CNT_W'(never_used + 1'b1);
          end
        end
        csl_pkg::U_LINK_PREV: begin
          if (prev_is_header) begin
            header_link <= PTR_W'(node);
          end
          cursor_prev <= PTR_W'(node);
        end
        csl_pkg::U_UNLINK: begin
          if (prev_is_header) begin
            header_link <= nl_rdata;
          end
          if (free_top < CNT_CAP) begin
            free_top <= CNT_W'(free_top + 1'b1);
          end
          cur <= nl_rdata;
        end
        csl_pkg::U_STEP: begin
          cursor_prev <= cur;
          cur         <= nl_rdata;
        end
        csl_pkg::U_RESTART: begin
          cursor_prev <= HEADER_CODE;
          cur         <= header_link;
        end
        csl_pkg::U_CLEAR: begin
          header_link <= NULL_CODE;
          cursor_prev <= HEADER_CODE;
          cur         <= NULL_CODE;
          free_top    <= '0;
          never_used  <= '0;
        end
        default: begin
        end
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.uop)
      csl_pkg::U_WAIT: begin
        val    <= val_wide[DATA_WIDTH-1:0];
        status <= csl_pkg::ST_OK;
      end
      csl_pkg::U_ALLOC: begin
        from_stack <= (free_top != '0);
        node       <= never_used[IDX_W-1:0];
      end
      csl_pkg::U_LINK_NEW: begin
        node <= node_sel;
      end
      csl_pkg::U_ST_FULL: begin
        status <= csl_pkg::ST_FULL;
      end
      csl_pkg::U_LOAD_VAL: begin
        cur_val <= nv_rdata;
      end
      csl_pkg::U_CHK_END: begin
        status <= at_end ? csl_pkg::ST_END : csl_pkg::ST_OK;
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_value  <= cur_wide[csl_pkg::VALUE_W-1:0];
      out_status <= status;
      out_at_end <= at_end;
      out_empty  <= (header_link >= NULL_CODE);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cursor_sequence_list_top.sv @@
// Cursor sequence list: a fixed-capacity singly linked list with a cursor.
// The request stream carries an opcode in tuser and a value in tdata; each
// request returns one result beat with the current value and status flags.
// Requests are taken when the sequencer is idle, one at a time; a result
// beat is valid in the same cycle that the sequencer returns to idle. The
// microprogram gives each registered read of the link, value or free stack
// memory and each write to the link memory's single write port its own step.
// An unused opcode goes straight to output; read checks the end; clear
// clears; restart loads the value; a remove or advance at the end tests and
// checks the end; an insert into a full store allocates and flags full;
// insert allocates and links; remove and advance test, unlink or step, load.
// The result sits in an output register; the next request is accepted while
// it waits, and the sequencer holds in its final step only if a second
// result is ready before the first has been taken.
// Reset empties the list and parks the cursor at the front; the node
// memories need no clearing pass, so requests are accepted right after
// reset. A clear request does the same in one step.
// Depends on csl_pkg, csl_seq, csl_datapath and csl_ram.
`timescale 1ns / 1ps
`default_nettype none

module cursor_sequence_list_top #(
  parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [31:0] s_tdata,   // [31:0] value
  input  wire  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [31:0]       m_tdata,   // [31:0] current_value
  output logic [3:0]        m_tuser    // [1:0] status, [2] at_end, [3] is_empty
);

  csl_pkg::ctrl_t  ctrl;
  csl_pkg::flags_t flags;
  logic [csl_pkg::STATUS_W-1:0] out_status;
  logic                         out_at_end;
  logic                         out_empty;

  csl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tuser),
    .flags    (flags),
    .ready    (s_tready),
    .ctrl     (ctrl)
  );

  csl_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .value      (s_tdata),
    .flags      (flags),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (m_tdata),
    .out_status (out_status),
    .out_at_end (out_at_end),
    .out_empty  (out_empty)
  );

  assign m_tuser = {out_empty, out_at_end, out_status};

endmodule

`default_nettype wire
